/* rtl/scc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, constants and helpers of the shock capture coefficient block.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MAX_ELEMENTS = 4096;
  localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int IDX_W        = 12;
  localparam int COEF_W       = 31;

  localparam logic [47:0] TOL_Q32   = 48'd4295;
  localparam logic [46:0] GRAD_MAX  = 47'h7FFF_FFFF_FFFF;
  localparam logic [30:0] Q16_MAX   = 31'h7FFF_FFFF;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_NX, S_NY, S_NACC,
    S_GXH, S_GXL, S_GXF, S_GYL, S_GYF,
    S_NORM, S_SQA, S_SQB, S_SQS, S_ROOT,
    S_RV1, S_RV2, S_RV3, S_RV4, S_RV5,
    S_DIVI, S_DIV, S_BLEND, S_OMUL, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_DY, MUL_DX, MUL_XH, MUL_XL, MUL_YH, MUL_YL,
    MUL_AA, MUL_BB, MUL_RX, MUL_RY, MUL_RG, MUL_OUT
  } mul_sel_t;

  typedef enum logic [4:0] {
    ACT_NONE, ACT_CLR, ACT_LOAD, ACT_ACCX, ACT_ACCY, ACT_PH, ACT_GX, ACT_GY,
    ACT_SHIFT, ACT_SQ_LOAD, ACT_SQ_INIT, ACT_ROOT, ACT_NORM_SET, ACT_R_LOAD,
    ACT_R_ADD, ACT_R_SRC, ACT_DIV_INIT, ACT_DIV, ACT_BLEND, ACT_OUT
  } act_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    act_t     act;
  } cmd_t;

  typedef struct packed {
    logic end_item;
    logic fit;
    logic root_last;
    logic div_skip;
    logic div_last;
    logic clr_last;
    logic out_busy;
  } status_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/scc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/scc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer: walks the datapath through accumulate, scale, root, divide, blend.
// ----------------------------------------------------------------------------
module scc_ctrl import scc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire status_t status,
  output logic         in_stall,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.mul_sel = MUL_NONE;
    cmd.act     = ACT_NONE;
    in_stall    = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.act = ACT_CLR;
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.act   = ACT_LOAD;
          state_nxt = S_NX;
        end
      end
      S_NX: begin
        cmd.mul_sel = MUL_DY;
        state_nxt   = S_NY;
      end
      S_NY: begin
        cmd.act     = ACT_ACCX;
        cmd.mul_sel = MUL_DX;
        state_nxt   = S_NACC;
      end
      S_NACC: begin
        cmd.act   = ACT_ACCY;
        state_nxt = status.end_item ? S_GXH : S_IDLE;
      end
      S_GXH: begin
        cmd.mul_sel = MUL_XH;
        state_nxt   = S_GXL;
      end
      S_GXL: begin
        cmd.act     = ACT_PH;
        cmd.mul_sel = MUL_XL;
        state_nxt   = S_GXF;
      end
      S_GXF: begin
        cmd.act     = ACT_GX;
        cmd.mul_sel = MUL_YH;
        state_nxt   = S_GYL;
      end
      S_GYL: begin
        cmd.act     = ACT_PH;
        cmd.mul_sel = MUL_YL;
        state_nxt   = S_GYF;
      end
      S_GYF: begin
        cmd.act   = ACT_GY;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (status.fit) begin
          state_nxt = S_SQA;
        end else begin
          cmd.act = ACT_SHIFT;
        end
      end
      S_SQA: begin
        cmd.mul_sel = MUL_AA;
        state_nxt   = S_SQB;
      end
      S_SQB: begin
        cmd.act     = ACT_SQ_LOAD;
        cmd.mul_sel = MUL_BB;
        state_nxt   = S_SQS;
      end
      S_SQS: begin
        cmd.act   = ACT_SQ_INIT;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.act = ACT_ROOT;
        if (status.root_last) state_nxt = S_RV1;
      end
      S_RV1: begin
        cmd.act     = ACT_NORM_SET;
        cmd.mul_sel = MUL_RX;
        state_nxt   = S_RV2;
      end
      S_RV2: begin
        cmd.act     = ACT_R_LOAD;
        cmd.mul_sel = MUL_RY;
        state_nxt   = S_RV3;
      end
      S_RV3: begin
        cmd.act     = ACT_R_ADD;
        cmd.mul_sel = MUL_RG;
        state_nxt   = S_RV4;
      end
      S_RV4: begin
        cmd.act   = ACT_R_ADD;
        state_nxt = S_RV5;
      end
      S_RV5: begin
        cmd.act   = ACT_R_SRC;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.act   = ACT_DIV_INIT;
        state_nxt = status.div_skip ? S_BLEND : S_DIV;
      end
      S_DIV: begin
        cmd.act = ACT_DIV;
        if (status.div_last) state_nxt = S_BLEND;
      end
      S_BLEND: begin
        cmd.act   = ACT_BLEND;
        state_nxt = S_OMUL;
      end
      S_OMUL: begin
        cmd.mul_sel = MUL_OUT;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.act   = ACT_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/scc_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scc_dp
// Datapath: shared multiplier, accumulators, root and divide iterations,
// coefficient store and output register.
// ----------------------------------------------------------------------------
module scc_dp import scc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic               cfg_valid,
  input  wire logic signed [31:0] cfg_data,
  input  wire logic signed [31:0] in_node_value,
  input  wire logic signed [31:0] in_node_dy,
  input  wire logic signed [31:0] in_node_dx,
  input  wire logic               in_end_of_element,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic signed [31:0] in_center_value,
  input  wire logic signed [31:0] in_center_source,
  input  wire logic [30:0]        in_inv_area,
  input  wire logic [30:0]        in_elem_size,
  input  wire logic [IDX_W-1:0]   in_elem_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [30:0]             out_capture_coef
);

  // captured item
  logic signed [31:0] val_r, dy_r, dx_r, vx_r, vy_r, cv_r, src_r;
  logic               end_r;
  logic [30:0]        ia_r, h_r;
  logic [IDX_W-1:0]   idx_r;
  logic signed [31:0] react_r;

  logic signed [63:0] accx_r, accy_r;
  logic signed [65:0] p_r;
  logic [63:0]        ph_r;
  logic [46:0]        gx_r, gy_r, a_r, b_r;
  logic               gxn_r, gyn_r;
  logic [4:0]         s_r;
  logic [63:0]        sq_r, x_r, root_r, bit_r;
  logic [47:0]        norm_r;
  logic signed [63:0] r_r;
  logic [47:0]        rem_r;
  logic [30:0]        num_r, c_r, cb_r;
  logic [4:0]         dcnt_r;
  logic [ADDR_W-1:0]  clr_r;
  logic               o_ovf;
  logic [30:0]        o_sat;

  // coefficient store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [COEF_W-1:0] ram_wdata, ram_rdata;
  logic              in_range;

  scc_ram #(.WIDTH(COEF_W), .DEPTH(MAX_ELEMENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ADDR_W'(idx_r)),
    .rdata (ram_rdata)
  );

  assign in_range = 32'(idx_r) < 32'(MAX_ELEMENTS);

  function automatic logic signed [32:0] in_sx(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  // magnitudes and operand select
  logic [63:0]        mx, my;
  logic signed [32:0] op_a, op_b, sqx, sqy;
  logic [63:0]        scaled_t;
  logic [47:0]        t48;
  logic [46:0]        gscale;
  logic [63:0]        rm;
  logic               tiny_grad, ovf;
  logic [48:0]        rem2;
  logic               ge;
  logic [63:0]        root_plus;
  logic [32:0]        blend_sum;
  logic [30:0]        prev;
  logic signed [63:0] src_neg;

  assign mx  = accx_r[63] ? 64'(-accx_r) : 64'(accx_r);
  assign my  = accy_r[63] ? 64'(-accy_r) : 64'(accy_r);
  assign sqx = gxn_r ? -{2'b00, gx_r[46:16]} : {2'b00, gx_r[46:16]};
  assign sqy = gyn_r ? -{2'b00, gy_r[46:16]} : {2'b00, gy_r[46:16]};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MUL_DY:  begin op_a = 33'(in_sx(dy_r));  op_b = 33'(in_sx(val_r)); end
      MUL_DX:  begin op_a = 33'(in_sx(dx_r));  op_b = 33'(in_sx(val_r)); end
      MUL_XH:  begin op_a = {1'b0, mx[63:32]}; op_b = {2'b00, ia_r}; end
      MUL_XL:  begin op_a = {1'b0, mx[31:0]};  op_b = {2'b00, ia_r}; end
      MUL_YH:  begin op_a = {1'b0, my[63:32]}; op_b = {2'b00, ia_r}; end
      MUL_YL:  begin op_a = {1'b0, my[31:0]};  op_b = {2'b00, ia_r}; end
      MUL_AA:  begin op_a = {2'b00, a_r[30:0]}; op_b = {2'b00, a_r[30:0]}; end
      MUL_BB:  begin op_a = {2'b00, b_r[30:0]}; op_b = {2'b00, b_r[30:0]}; end
      MUL_RX:  begin op_a = 33'(in_sx(vx_r));  op_b = sqx; end
      MUL_RY:  begin op_a = 33'(in_sx(vy_r));  op_b = sqy; end
      MUL_RG:  begin op_a = 33'(in_sx(react_r)); op_b = 33'(in_sx(cv_r)); end
      MUL_OUT: begin op_a = {2'b00, cb_r};     op_b = {2'b00, h_r}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // gradient scale: (ph << 15) + (pl >> 17), saturated
  always_comb begin
    scaled_t = 64'(ph_r[31:0]) << 15;
    t48      = 48'(scaled_t) + 48'(p_r[63:17]);
    if (ph_r[63:32] != 32'd0 || t48[47]) begin
      gscale = GRAD_MAX;
    end else begin
      gscale = t48[46:0];
    end
  end

  assign rm        = r_r[63] ? 64'(-r_r) : 64'(r_r);
  assign tiny_grad = norm_r < TOL_Q32;
  assign ovf       = rm >= (64'(norm_r) << 15);
  assign rem2      = {rem_r, num_r[30]};
  assign ge        = rem2 >= {1'b0, norm_r};
  assign root_plus = root_r + bit_r;
  assign prev      = in_range ? ram_rdata : 31'd0;
  assign blend_sum = {2'b00, c_r} + {1'b0, prev, 1'b0};
  assign src_neg   = -{{16{src_r[31]}}, src_r, 16'd0};

  always_comb begin
    o_sat = p_r[46:16];
    o_ovf = p_r[62:47] != 16'd0;
    if (o_ovf) o_sat = Q16_MAX;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    if (cmd.act == ACT_CLR) begin
      ram_we = 1'b1;
    end else if (cmd.act == ACT_BLEND) begin
      ram_we    = in_range;
      ram_waddr = ADDR_W'(idx_r);
      ram_wdata = blend_sum[32:2];
    end
  end

  assign status.end_item  = end_r;
  assign status.fit       = (a_r[46:31] == 16'd0) && (b_r[46:31] == 16'd0);
  assign status.root_last = bit_r[0];
  assign status.div_skip  = tiny_grad || ovf;
  assign status.div_last  = dcnt_r == 5'd0;
  assign status.clr_last  = 32'(clr_r) == 32'(MAX_ELEMENTS - 1);
  assign status.out_busy  = out_valid && out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      react_r   <= '0;
      accx_r    <= '0;
      accy_r    <= '0;
      clr_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) react_r <= cfg_data;
      if (cmd.act == ACT_CLR) clr_r <= clr_r + 1'b1;
      if (cmd.act == ACT_ACCX) accx_r <= sat_add64(accx_r, p_r[63:0]);
      if (cmd.act == ACT_ACCY) accy_r <= sat_add64(accy_r, p_r[63:0]);
      if (cmd.act == ACT_OUT) begin
        accx_r    <= '0;
        accy_r    <= '0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) p_r <= op_a * op_b;
    case (cmd.act)
      ACT_LOAD: begin
        val_r <= in_node_value;
        dy_r  <= in_node_dy;
        dx_r  <= in_node_dx;
        end_r <= in_end_of_element;
        vx_r  <= in_vel_x;
        vy_r  <= in_vel_y;
        cv_r  <= in_center_value;
        src_r <= in_center_source;
        ia_r  <= in_inv_area;
        h_r   <= in_elem_size;
        idx_r <= in_elem_index;
      end
      ACT_PH: ph_r <= p_r[63:0];
      ACT_GX: begin
        gx_r  <= gscale;
        gxn_r <= accx_r[63];
      end
      ACT_GY: begin
        gy_r  <= gscale;
        gyn_r <= accy_r[63];
        a_r   <= gx_r;
        b_r   <= gscale;
        s_r   <= '0;
      end
      ACT_SHIFT: begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        s_r <= s_r + 1'b1;
      end
      ACT_SQ_LOAD: sq_r <= p_r[63:0];
      ACT_SQ_INIT: begin
        x_r    <= sq_r + p_r[63:0];
        root_r <= '0;
        bit_r  <= 64'd1 << 62;
      end
      ACT_ROOT: begin
        if (x_r >= root_plus) begin
          x_r    <= x_r - root_plus;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ACT_NORM_SET: norm_r <= 48'(root_r[31:0]) << s_r;
      ACT_R_LOAD:   r_r <= p_r[63:0];
      ACT_R_ADD:    r_r <= sat_add64(r_r, p_r[63:0]);
      ACT_R_SRC:    r_r <= sat_add64(r_r, src_neg);
      ACT_DIV_INIT: begin
        c_r    <= (!tiny_grad && ovf) ? Q16_MAX : 31'd0;
        rem_r  <= rm[62:15];
        num_r  <= {rm[14:0], 16'd0};
        dcnt_r <= 5'd30;
      end
      ACT_DIV: begin
        rem_r  <= ge ? 48'(rem2 - {1'b0, norm_r}) : rem2[47:0];
        num_r  <= num_r << 1;
        c_r    <= {c_r[29:0], ge};
        dcnt_r <= dcnt_r - 1'b1;
      end
      ACT_BLEND: cb_r <= blend_sum[32:2];
      ACT_OUT:   out_capture_coef <= o_sat;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/shock_capture_coefficient_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shock_capture_coefficient_top
// Discontinuity-capturing coefficient for triangle elements, Q16.16.
// ----------------------------------------------------------------------------
// Each triangle arrives as three node transfers; the last one, flagged by
// end_of_element, also carries the element data and yields one result
// transfer. After reset the block zeroes all MAX_ELEMENTS entries of the
// coefficient store and holds in_stall high meanwhile; configuration
// writes are taken at any time. A node transfer occupies the block while
// the shared multiplier does the two products in turn. An end transfer
// steps the multiplier through the gradient, prescales the norm, runs the
// one-bit-a-step square root and the restoring divider (skipped when the
// gradient is below tolerance or the quotient saturates). The result
// register lets the next element start while a result still waits on
// out_stall.
// ----------------------------------------------------------------------------
module shock_capture_coefficient_top import scc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // node / element input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_node_value,
  input  wire logic signed [31:0] in_node_dy,
  input  wire logic signed [31:0] in_node_dx,
  input  wire logic               in_end_of_element,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic signed [31:0] in_center_value,
  input  wire logic signed [31:0] in_center_source,
  input  wire logic [30:0]        in_inv_area,
  input  wire logic [30:0]        in_elem_size,
  input  wire logic [IDX_W-1:0]   in_elem_index,
  // result
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [30:0]             out_capture_coef,
  // reaction coefficient write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic signed [31:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // register is writable at any time, so the port never pushes back
  assign cfg_ready = 1'b1;

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  scc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_node_value     (in_node_value),
    .in_node_dy        (in_node_dy),
    .in_node_dx        (in_node_dx),
    .in_end_of_element (in_end_of_element),
    .in_vel_x          (in_vel_x),
    .in_vel_y          (in_vel_y),
    .in_center_value   (in_center_value),
    .in_center_source  (in_center_source),
    .in_inv_area       (in_inv_area),
    .in_elem_size      (in_elem_size),
    .in_elem_index     (in_elem_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_capture_coef  (out_capture_coef)
  );

  // one item in flight: a transfer is followed by a busy cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item still in work");

  // the store is never written in a cycle that takes an input transfer
  a_no_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_CLR || cmd.act == ACT_BLEND) |-> in_stall)
    else $error("coefficient store written while accepting input");

  // issuing a result always shows a valid result next cycle
  a_out_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_OUT) |=> out_valid)
    else $error("result issued but not presented");

endmodule
`default_nettype wire
